// File: rtl/core/vcg_greedy_batch_allocator_unit_macros.svh
// Assertion macros shared by the allocator RTL.
// Depends on nothing; files that check their own logic include this header.
`ifndef VCG_GREEDY_BATCH_ALLOCATOR_UNIT_MACROS_SVH
`define VCG_GREEDY_BATCH_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VGBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VGBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/vgba_pkg.sv
// Types and constants shared by the allocator modules.
// Depends on nothing.
package vgba_pkg;

    localparam int ID_W        = 32;
    localparam int TIME_W      = 24;
    localparam int CAP_W       = 16;
    localparam int DEM_W       = 20;
    localparam int WEL_W       = 40;
    localparam int PAY_W       = 44;
    localparam int SUM_W       = 47;
    localparam int KEY_W       = TIME_W + 1;
    localparam int ENT_W       = ID_W + TIME_W + CAP_W;
    localparam int MAX_RESULTS = 16;
    localparam int DIV_CNT_W   = $clog2(WEL_W);

    typedef struct packed {
        logic load_in;
        logic j_inc;
        logic found_set;
        logic tbl_write;
        logic sort_init;
        logic rd_i;
        logic lat_i;
        logic cmp_j;
        logic srt_write;
        logic full_begin;
        logic pass_init;
        logic eval;
        logic acc;
        logic wall_set;
        logic out_load;
        logic next_p;
    } cmd_t;

    typedef struct packed {
        logic j_end;
        logic hit;
        logic last;
        logic dem_zero;
        logic i_end;
        logic pass_end;
        logic div_done;
        logic full;
        logic none_won;
        logic p_last;
    } sts_t;

endpackage

// File: rtl/core/vgba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module vgba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/vgba_div.sv
// Restoring divider that returns floor(dividend * 2^24 / divisor), one bit a cycle.
// Depends on vgba_pkg.
module vgba_div
    import vgba_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [CAP_W-1:0]  dividend,
    input  logic [TIME_W-1:0] divisor,
    output logic              done,
    output logic [WEL_W-1:0]  quotient
);
    logic [TIME_W-1:0]    rem_reg;
    logic [WEL_W-1:0]     dvd_reg;
    logic [TIME_W-1:0]    dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [TIME_W:0]      shifted;
    logic [TIME_W:0]      diff;
    logic                 ge;

    assign shifted = {rem_reg, dvd_reg[WEL_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg && cnt_reg == DIV_CNT_W'(WEL_W - 1)) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {dividend, {(WEL_W - CAP_W){1'b0}}};
            rem_reg <= '0;
            dsr_reg <= divisor;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
            dvd_reg <= {dvd_reg[WEL_W-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;
endmodule

// File: rtl/core/vgba_dp.sv
// Datapath: bid table, ranked copy, greedy pass engine and result registers.
// Depends on vgba_pkg, vgba_ram, vgba_div and the assertion macros header.
module vgba_dp
    import vgba_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [ID_W-1:0]   in_id,
    input  logic [TIME_W-1:0] in_time,
    input  logic [CAP_W-1:0]  in_cap,
    input  logic [DEM_W-1:0]  in_demand,
    input  logic              in_last,
    output logic [ID_W-1:0]   out_id,
    output logic [CAP_W-1:0]  out_granted,
    output logic [WEL_W-1:0]  out_welfare,
    output logic [PAY_W-1:0]  out_payment,
    output logic              out_last
);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] time_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [DEM_W-1:0]  demand_reg;
    logic              last_reg;
    logic [CW-1:0]     count_reg, j_reg, i_reg, rank_reg, q_reg, p_reg;
    logic [CW-1:0]     visited_reg, emit_reg;
    logic [IW-1:0]     slot_reg;
    logic              found_reg, full_reg, skip_reg;
    logic [ENT_W-1:0]  ki_reg;
    logic [DEM_W-1:0]  left_reg;
    logic [SUM_W-1:0]  acc_reg, wall_reg;
    logic [CAP_W-1:0]  g_reg, owng_reg;
    logic [TIME_W-1:0] cur_time_reg;
    logic [ID_W-1:0]   cur_id_reg, ownid_reg;
    logic [WEL_W-1:0]  own_reg;
    logic [ID_W-1:0]   o_id_reg;
    logic [CAP_W-1:0]  o_g_reg;
    logic [WEL_W-1:0]  o_w_reg;
    logic [PAY_W-1:0]  o_p_reg;
    logic              o_last_reg;

    logic              tbl_we;
    logic [IW-1:0]     tbl_waddr, tbl_raddr;
    logic [ENT_W-1:0]  tbl_rdata, srt_rdata;
    logic              has_room;
    logic [ID_W-1:0]   t_id, s_id;
    logic [TIME_W-1:0] t_time, s_time, ki_time;
    logic [CAP_W-1:0]  s_cap;
    logic [KEY_W-1:0]  key_i, key_j;
    logic              less;
    logic [CAP_W-1:0]  g_val;
    logic              div_done;
    logic [WEL_W-1:0]  quot, quot_eff;
    logic [SUM_W:0]    tot;
    logic [SUM_W:0]    pay;
    logic [CW-1:0]     emit_val;

    assign has_room  = count_reg < CW'(MAX_NODES);
    assign tbl_we    = cmd.tbl_write && (found_reg || has_room);
    assign tbl_waddr = found_reg ? slot_reg : count_reg[IW-1:0];
    assign tbl_raddr = cmd.rd_i ? i_reg[IW-1:0] : j_reg[IW-1:0];

    vgba_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NODES)) u_tbl (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata ({id_reg, time_reg, cap_reg}),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    vgba_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NODES)) u_srt (
        .aclk  (aclk),
        .we    (cmd.srt_write),
        .waddr (rank_reg[IW-1:0]),
        .wdata (ki_reg),
        .raddr (q_reg[IW-1:0]),
        .rdata (srt_rdata)
    );

    assign t_id    = tbl_rdata[ENT_W-1 -: ID_W];
    assign t_time  = tbl_rdata[CAP_W +: TIME_W];
    assign ki_time = ki_reg[CAP_W +: TIME_W];
    assign s_id    = srt_rdata[ENT_W-1 -: ID_W];
    assign s_time  = srt_rdata[CAP_W +: TIME_W];
    assign s_cap   = srt_rdata[CAP_W-1:0];

    assign key_i = (ki_time == '0) ? {1'b1, {TIME_W{1'b0}}} : {1'b0, ki_time};
    assign key_j = (t_time == '0) ? {1'b1, {TIME_W{1'b0}}} : {1'b0, t_time};
    assign less  = (key_j < key_i) || ((key_j == key_i) && (j_reg < i_reg));

    assign g_val = ({{(DEM_W - CAP_W){1'b0}}, s_cap} < left_reg) ? s_cap
                                                                  : left_reg[CAP_W-1:0];

    vgba_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.eval),
        .dividend (g_val),
        .divisor  (s_time),
        .done     (div_done),
        .quotient (quot)
    );

    assign quot_eff = (cur_time_reg == '0) ? '0 : quot;
    assign tot      = {1'b0, acc_reg} + (SUM_W + 1)'(own_reg);
    assign pay      = (tot >= {1'b0, wall_reg}) ? (tot - {1'b0, wall_reg}) : '0;
    assign emit_val = (32'(visited_reg) > MAX_RESULTS) ? CW'(MAX_RESULTS) : visited_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            full_reg  <= 1'b0;
        end else begin
            if (tbl_we && !found_reg) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.full_begin) begin
                full_reg <= 1'b1;
            end else if (cmd.wall_set) begin
                full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            id_reg     <= in_id;
            time_reg   <= in_time;
            cap_reg    <= in_cap;
            demand_reg <= in_demand;
            last_reg   <= in_last;
            j_reg      <= '0;
            found_reg  <= 1'b0;
        end
        if (cmd.j_inc) begin
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.found_set) begin
            found_reg <= 1'b1;
            slot_reg  <= j_reg[IW-1:0];
        end
        if (cmd.sort_init) begin
            i_reg <= '0;
        end
        if (cmd.lat_i) begin
            ki_reg   <= tbl_rdata;
            j_reg    <= '0;
            rank_reg <= '0;
        end
        if (cmd.cmp_j) begin
            if (less) begin
                rank_reg <= rank_reg + 1'b1;
            end
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.srt_write) begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.full_begin) begin
            p_reg <= '0;
        end
        if (cmd.pass_init) begin
            q_reg       <= '0;
            left_reg    <= demand_reg;
            acc_reg     <= '0;
            visited_reg <= '0;
        end
        if (cmd.eval) begin
            g_reg        <= g_val;
            cur_time_reg <= s_time;
            cur_id_reg   <= s_id;
            skip_reg     <= !full_reg && (q_reg == p_reg);
        end
        if (cmd.acc) begin
            if (skip_reg) begin
                own_reg   <= quot_eff;
                owng_reg  <= g_reg;
                ownid_reg <= cur_id_reg;
            end else begin
                acc_reg     <= acc_reg + SUM_W'(quot_eff);
                left_reg    <= left_reg - DEM_W'(g_reg);
                visited_reg <= visited_reg + 1'b1;
            end
            q_reg <= q_reg + 1'b1;
        end
        if (cmd.wall_set) begin
            wall_reg <= acc_reg;
            emit_reg <= emit_val;
        end
        if (cmd.out_load) begin
            o_id_reg   <= ownid_reg;
            o_g_reg    <= owng_reg;
            o_w_reg    <= own_reg;
            o_p_reg    <= pay[PAY_W-1:0];
            o_last_reg <= ({1'b0, p_reg} + 1'b1) == {1'b0, emit_reg};
        end
        if (cmd.next_p) begin
            p_reg <= p_reg + 1'b1;
        end
    end

    always_comb begin
        sts.j_end    = j_reg == count_reg;
        sts.hit      = t_id == id_reg;
        sts.last     = last_reg;
        sts.dem_zero = demand_reg == '0;
        sts.i_end    = i_reg == count_reg;
        sts.pass_end = (q_reg == count_reg) || (left_reg == '0);
        sts.div_done = div_done;
        sts.full     = full_reg;
        sts.none_won = visited_reg == '0;
        sts.p_last   = ({1'b0, p_reg} + 1'b1) == {1'b0, emit_reg};
    end

    assign out_id      = o_id_reg;
    assign out_granted = o_g_reg;
    assign out_welfare = o_w_reg;
    assign out_payment = o_p_reg;
    assign out_last    = o_last_reg;

`include "vcg_greedy_batch_allocator_unit_macros.svh"

    `VGBA_ASSERT_NEXT(a_count_grows, aclk, aresetn, tbl_we && !found_reg, count_reg == $past(count_reg) + 1'b1, "table count did not grow on append")
    `VGBA_ASSERT_SAME(a_count_bound, aclk, aresetn, cmd.srt_write, rank_reg < count_reg, "rank out of range")
endmodule

// File: rtl/core/vgba_ctrl.sv
// Controller state machine: sequences load, sort, greedy passes and result hand-off.
// Depends on vgba_pkg and the assertion macros header.
module vgba_ctrl
    import vgba_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd,
    input  sts_t sts
);
    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_SRD    = 15'b000000000000010,
        ST_SCMP   = 15'b000000000000100,
        ST_WR     = 15'b000000000001000,
        ST_IRD    = 15'b000000000010000,
        ST_ILAT   = 15'b000000000100000,
        ST_JRD    = 15'b000000001000000,
        ST_JCMP   = 15'b000000010000000,
        ST_SWR    = 15'b000000100000000,
        ST_PSTART = 15'b000001000000000,
        ST_PRD    = 15'b000010000000000,
        ST_PEV    = 15'b000100000000000,
        ST_PDIV   = 15'b001000000000000,
        ST_PEND   = 15'b010000000000000,
        ST_OUT    = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SRD;
                end
            end
            ST_SRD: begin
                state_next = sts.j_end ? ST_WR : ST_SCMP;
            end
            ST_SCMP: begin
                if (sts.hit) begin
                    cmd.found_set = 1'b1;
                    state_next    = ST_WR;
                end else begin
                    cmd.j_inc  = 1'b1;
                    state_next = ST_SRD;
                end
            end
            ST_WR: begin
                cmd.tbl_write = 1'b1;
                cmd.sort_init = 1'b1;
                state_next = (sts.last && !sts.dem_zero) ? ST_IRD : ST_IDLE;
            end
            ST_IRD: begin
                if (sts.i_end) begin
                    cmd.full_begin = 1'b1;
                    state_next     = ST_PSTART;
                end else begin
                    cmd.rd_i   = 1'b1;
                    state_next = ST_ILAT;
                end
            end
            ST_ILAT: begin
                cmd.lat_i  = 1'b1;
                state_next = ST_JRD;
            end
            ST_JRD: begin
                state_next = sts.j_end ? ST_SWR : ST_JCMP;
            end
            ST_JCMP: begin
                cmd.cmp_j  = 1'b1;
                state_next = ST_JRD;
            end
            ST_SWR: begin
                cmd.srt_write = 1'b1;
                state_next    = ST_IRD;
            end
            ST_PSTART: begin
                cmd.pass_init = 1'b1;
                state_next    = ST_PRD;
            end
            ST_PRD: begin
                state_next = sts.pass_end ? ST_PEND : ST_PEV;
            end
            ST_PEV: begin
                cmd.eval   = 1'b1;
                state_next = ST_PDIV;
            end
            ST_PDIV: begin
                if (sts.div_done) begin
                    cmd.acc    = 1'b1;
                    state_next = ST_PRD;
                end
            end
            ST_PEND: begin
                if (sts.full) begin
                    cmd.wall_set = 1'b1;
                    state_next   = sts.none_won ? ST_IDLE : ST_PSTART;
                end else begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (sts.p_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.next_p = 1'b1;
                        state_next = ST_PSTART;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_OUT;

`include "vcg_greedy_batch_allocator_unit_macros.svh"

    `VGBA_ASSERT_NEXT(a_div_wait, aclk, aresetn, state_reg == ST_PDIV && !sts.div_done, state_reg == ST_PDIV, "left divider wait early")
    `VGBA_ASSERT_NEXT(a_rerun_out, aclk, aresetn, state_reg == ST_PEND && !sts.full, m_tvalid, "rerun end did not present an item")
endmodule

// File: rtl/core/vcg_greedy_batch_allocator_unit.sv
// Top level of the VCG greedy batch allocator: ties the controller to the datapath.
// Depends on vgba_pkg, vgba_ctrl and vgba_dp.
//
// Bids enter on the s_ channel, one item each; s_tlast marks the bid that
// carries the demand and starts a solve if that demand is nonzero. A bid
// whose id is held replaces that entry, a new id is appended while room
// remains. Results leave on the m_ channel, one item per allocated node in
// rank order up to MAX_RESULTS items, m_tlast on the last. Loading a bid
// runs a linear id search through the table memory. A solve ranks the bids
// by comparing every pair, then runs one full greedy pass and one more pass
// per reported winner; each pass step waits for the bit-serial welfare divider.
// One item is in flight at a time: s_tready is high only while idle.
// A result is held in the output register while m_tready is low, and the
// solve waits for it. Reset empties the bid table; its contents are not
// cleared and need no clearing pass.
module vcg_greedy_batch_allocator_unit
    import vgba_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // bidder_id[31:0], time_q8[55:32], batch_cap[71:56], demand[91:72], zero fill
    input  logic [95:0]  s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // winner_id[31:0], granted[47:32], welfare[87:48], payment[131:88], zero fill
    output logic [135:0] m_tdata,
    output logic         m_tlast
);
    cmd_t              cmd;
    sts_t              sts;
    logic [ID_W-1:0]   out_id;
    logic [CAP_W-1:0]  out_granted;
    logic [WEL_W-1:0]  out_welfare;
    logic [PAY_W-1:0]  out_payment;

    vgba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    vgba_dp #(.MAX_NODES(MAX_NODES)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_id       (s_tdata[31:0]),
        .in_time     (s_tdata[55:32]),
        .in_cap      (s_tdata[71:56]),
        .in_demand   (s_tdata[91:72]),
        .in_last     (s_tlast),
        .out_id      (out_id),
        .out_granted (out_granted),
        .out_welfare (out_welfare),
        .out_payment (out_payment),
        .out_last    (m_tlast)
    );

    assign m_tdata = {4'b0, out_payment, out_welfare, out_granted, out_id};
endmodule
